>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// implication in the next cycle, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// implication in the next cycle, checked also while reset is asserted
`define ASSERT_IMPLY_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: implication under reset");

`endif

>>> hdl/gsao_pkg.sv
`timescale 1ns / 1ps

package gsao_pkg;

    localparam int NUM_AXES    = 3;
    localparam int AXIS_W      = $clog2(NUM_AXES);
    localparam int RAW_W       = 16;
    localparam int OFS_W       = 24;
    localparam int THR_W       = 10;
    localparam int FRAC_W      = 8;
    localparam int PRE_W       = 25;
    localparam int RATE_W      = 26;
    localparam int DIFF_W      = RATE_W + 1;
    localparam int CNT_W       = 13;
    localparam int ACNT_W      = 7;
    localparam int SUM_W       = 33;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 80;
    localparam int OUT_USER_W  = 8;

    localparam int AVG_SAMPLES = 50;
    localparam int STILL_CAP   = 6000;
    localparam int LEARN_LIMIT = 10 * AVG_SAMPLES;

    // magnitude of a finished sum is at most AVG_SAMPLES * 2^(RATE_W-1)
    localparam int DIV_MAG_W   = RATE_W - 1 + $clog2(AVG_SAMPLES);
    localparam int RECIP_W     = DIV_MAG_W + 1;
    localparam int RECIP_SHIFT = DIV_MAG_W + $clog2(AVG_SAMPLES);
    localparam int PROD_W      = DIV_MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((longint'(1) <<< RECIP_SHIFT) + longint'(AVG_SAMPLES - 1))
                 / longint'(AVG_SAMPLES));

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_OFS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_THR   = CFG_IDX_W'(3);

    typedef logic [NUM_AXES-1:0][PRE_W-1:0] pre_vec_t;
    typedef logic [NUM_AXES-1:0][OFS_W-1:0] ofs_vec_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hdl/gsao_front.sv
`timescale 1ns / 1ps

module gsao_front
    import gsao_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ofs_vec_t             manual_offset,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // raw_rate_x [15:0], raw_rate_y [31:16], raw_rate_z [47:32]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 q_valid,
    output pre_vec_t             q_data,
    input  logic                 q_ready
);

    pre_vec_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    pre_vec_t   pre;

    // scale raw rate and remove the manual bias
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pre[a] = PRE_W'($signed({s_axis_tdata[a*RAW_W +: RAW_W], {FRAC_W{1'b0}}}))
                   - PRE_W'($signed(manual_offset[a]));
        end
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign pop           = q_valid && q_ready;
    assign q_data        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= pre;
        end
    end

endmodule

>>> hdl/gsao_div.sv
`timescale 1ns / 1ps

module gsao_div
    import gsao_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_MAG_W-1:0] mag_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;
    logic                 mul_reg;
    logic                 done_reg;
    logic [SUM_W-1:0]     magnitude;
    logic [RATE_W-1:0]    quo_trunc;

    assign magnitude = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= req.start;
            done_reg <= mul_reg;
        end
    end

    // multiply by the rounded-up reciprocal, keep the high bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_reg <= magnitude[DIV_MAG_W-1:0];
            neg_reg <= req.dividend[SUM_W-1];
        end
        if (mul_reg)
        begin
            prod_reg <= mag_reg * RECIP_MUL;
        end
    end

    // truncate toward zero: divide the magnitude, then restore the sign
    assign quo_trunc    = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_trunc + RATE_W'(1)) : quo_trunc;

endmodule

>>> hdl/gsao_back.sv
`timescale 1ns / 1ps

module gsao_back
    import gsao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [THR_W-1:0]      motion_threshold,
    input  logic                  q_valid,
    input  pre_vec_t              q_data,
    output logic                  q_ready,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rate_out_x [25:0], rate_out_y [51:26], rate_out_z [77:52], zero [79:78]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // calibrated_mask [2:0], zero [7:3]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam logic PH_RUN = 1'b0;
    localparam logic PH_DIV = 1'b1;

    logic signed [RATE_W-1:0] cur_reg  [NUM_AXES];
    logic signed [RATE_W-1:0] prev_reg [NUM_AXES];
    logic [CNT_W-1:0]         sc_reg   [NUM_AXES];
    logic [ACNT_W-1:0]        ac_reg   [NUM_AXES];
    logic [SUM_W-1:0]         sum_reg  [NUM_AXES];
    logic [RATE_W-1:0]        off_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]      done_reg;
    logic [NUM_AXES-1:0]      pend_reg;
    logic [SUM_W-1:0]         dsum_reg [NUM_AXES];
    pre_vec_t                 hold_pre_reg;
    logic                     phase_reg;
    logic                     busy_reg;
    logic [AXIS_W-1:0]        div_axis_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic [OUT_USER_W-1:0]    out_user_reg;

    logic [CNT_W-1:0]         sc_next  [NUM_AXES];
    logic [ACNT_W-1:0]        ac_next  [NUM_AXES];
    logic [SUM_W-1:0]         sum_next [NUM_AXES];
    logic [RATE_W-1:0]        off_next [NUM_AXES];
    logic [NUM_AXES-1:0]      done_next;
    logic [SUM_W-1:0]         sum_add  [NUM_AXES];
    logic [NUM_AXES-1:0]      still;
    logic [NUM_AXES-1:0]      complete;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        abs_diff;
    logic [DIFF_W-1:0]        limit;

    pre_vec_t                 comp_pre;
    logic [RATE_W-1:0]        comp_off [NUM_AXES];
    logic [NUM_AXES-1:0]      comp_mask;
    logic signed [DIFF_W-1:0] comp_full;
    logic [RATE_W-1:0]        comp_rate [NUM_AXES];
    logic [OUT_DATA_W-1:0]    comp_data;

    logic                     out_free;
    logic                     step_fire;
    logic                     finish_fire;
    logic                     out_load;
    logic [AXIS_W-1:0]        sel_axis;

    assign limit = DIFF_W'({motion_threshold, {FRAC_W{1'b0}}});

    // motion check, axis by axis; a moving axis clears every counter
    always_comb
    begin
        diff     = '0;
        abs_diff = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sc_next[a] = sc_reg[a];
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff     = DIFF_W'(cur_reg[a]) - DIFF_W'(prev_reg[a]);
            abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            still[a] = (abs_diff < limit);
            if (still[a])
            begin
                sc_next[a] = sc_next[a] + CNT_W'(1);
            end
            else
            begin
                for (int b = 0; b < NUM_AXES; b++)
                begin
                    sc_next[b] = '0;
                end
            end
        end

        // learning phase
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ac_next[a]   = ac_reg[a];
            sum_next[a]  = sum_reg[a];
            off_next[a]  = off_reg[a];
            done_next[a] = done_reg[a];
            complete[a]  = 1'b0;
            sum_add[a]   = sum_reg[a]
                         + {{(SUM_W-RATE_W){cur_reg[a][RATE_W-1]}}, cur_reg[a]};
            if (sc_next[a] > CNT_W'(LEARN_LIMIT))
            begin
                if (!done_reg[a])
                begin
                    if ((ac_reg[a] + ACNT_W'(1)) >= ACNT_W'(AVG_SAMPLES))
                    begin
                        complete[a]  = 1'b1;
                        done_next[a] = 1'b1;
                        ac_next[a]   = '0;
                        sum_next[a]  = '0;
                    end
                    else
                    begin
                        ac_next[a]  = ac_reg[a] + ACNT_W'(1);
                        sum_next[a] = sum_add[a];
                    end
                end
                if (sc_next[a] >= CNT_W'(STILL_CAP))
                begin
                    sc_next[a] = CNT_W'(AVG_SAMPLES);
                end
            end
            else
            begin
                if (!done_reg[a])
                begin
                    off_next[a] = '0;
                    sum_next[a] = '0;
                end
                ac_next[a] = '0;
            end
        end
    end

    // compensation, fed by the live item or by the one held during division
    always_comb
    begin
        comp_pre  = (phase_reg == PH_DIV) ? hold_pre_reg : q_data;
        comp_mask = (phase_reg == PH_DIV) ? done_reg : done_next;
        comp_full = '0;
        comp_data = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            comp_off[a] = (phase_reg == PH_DIV) ? off_reg[a] : off_next[a];
            comp_full   = DIFF_W'($signed(comp_pre[a])) - DIFF_W'($signed(comp_off[a]));
            if (comp_full[DIFF_W-1] != comp_full[DIFF_W-2])
            begin
                comp_rate[a] = comp_full[DIFF_W-1] ? {1'b1, {(RATE_W-1){1'b0}}}
                                                   : {1'b0, {(RATE_W-1){1'b1}}};
            end
            else
            begin
                comp_rate[a] = comp_full[RATE_W-1:0];
            end
            comp_data[a*RATE_W +: RATE_W] = comp_rate[a];
        end
    end

    always_comb
    begin
        sel_axis = '0;
        for (int a = NUM_AXES - 1; a >= 0; a--)
        begin
            if (pend_reg[a])
            begin
                sel_axis = AXIS_W'(a);
            end
        end
    end

    assign out_free     = !out_valid_reg || m_axis_tready;
    assign q_ready      = (phase_reg == PH_RUN) && out_free;
    assign step_fire    = q_valid && q_ready;
    assign finish_fire  = (phase_reg == PH_DIV) && !busy_reg && (pend_reg == '0) && out_free;
    assign out_load     = (step_fire && (complete == '0)) || finish_fire;

    assign div_req.start    = (phase_reg == PH_DIV) && !busy_reg && (pend_reg != '0);
    assign div_req.dividend = dsum_reg[sel_axis];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                cur_reg[a]  <= '0;
                prev_reg[a] <= '0;
                sc_reg[a]   <= '0;
                ac_reg[a]   <= '0;
                sum_reg[a]  <= '0;
                off_reg[a]  <= '0;
            end
            done_reg      <= '0;
            pend_reg      <= '0;
            phase_reg     <= PH_RUN;
            busy_reg      <= 1'b0;
            div_axis_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (phase_reg)
                PH_RUN:
                begin
                    if (step_fire)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            prev_reg[a] <= cur_reg[a];
                            sc_reg[a]   <= sc_next[a];
                            ac_reg[a]   <= ac_next[a];
                            sum_reg[a]  <= sum_next[a];
                            off_reg[a]  <= off_next[a];
                        end
                        done_reg <= done_next;
                        if (complete != '0)
                        begin
                            pend_reg  <= complete;
                            phase_reg <= PH_DIV;
                        end
                        else
                        begin
                            for (int a = 0; a < NUM_AXES; a++)
                            begin
                                cur_reg[a] <= comp_rate[a];
                            end
                        end
                    end
                end
                PH_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        off_reg[div_axis_reg]  <= div_rsp.quotient;
                        pend_reg[div_axis_reg] <= 1'b0;
                        busy_reg               <= 1'b0;
                    end
                    else if (div_req.start)
                    begin
                        busy_reg     <= 1'b1;
                        div_axis_reg <= sel_axis;
                    end
                    else if (finish_fire)
                    begin
                        for (int a = 0; a < NUM_AXES; a++)
                        begin
                            cur_reg[a] <= comp_rate[a];
                        end
                        phase_reg <= PH_RUN;
                    end
                end
                default:
                begin
                    phase_reg <= PH_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && (complete != '0))
        begin
            hold_pre_reg <= q_data;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                dsum_reg[a] <= sum_add[a];
            end
        end
        if (out_load)
        begin
            out_data_reg <= comp_data;
            out_user_reg <= OUT_USER_W'(comp_mask);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> hdl/gyro_still_auto_offset.sv
// A result beat passes through the two-entry front FIFO and is then registered for output.
// Throughput: one sample per cycle unless the output stalls or a division runs, set by the
// combinational motion and learning update. A sample that closes an average stalls the back
// end while the shared reciprocal divider forms each finishing offset, then until its beat is out.
// Reset (rst_n, asynchronous, active low): all learned state, counters and offsets
// clear, manual offsets clear and the motion threshold returns to 5.
`timescale 1ns / 1ps

module gyro_still_auto_offset
    import gsao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFS_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // raw_rate_x [15:0], raw_rate_y [31:16], raw_rate_z [47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rate_out_x [25:0], rate_out_y [51:26], rate_out_z [77:52], zero [79:78]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // calibrated_mask [2:0], zero [7:3]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    ofs_vec_t         ofs_reg;
    logic [THR_W-1:0] thr_reg;
    logic             q_valid;
    logic             q_ready;
    pre_vec_t         q_data;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg <= '0;
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFS_X: ofs_reg[0] <= cfg_data;
                REG_OFS_Y: ofs_reg[1] <= cfg_data;
                REG_OFS_Z: ofs_reg[2] <= cfg_data;
                REG_THR:   thr_reg    <= cfg_data[THR_W-1:0];
                default:   thr_reg    <= thr_reg;
            endcase
        end
    end

    gsao_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .manual_offset (ofs_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_ready       (q_ready)
    );

    gsao_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gsao_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .motion_threshold (thr_reg),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_ready          (q_ready),
        .div_req          (div_req),
        .div_rsp          (div_rsp),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser)
    );

endmodule

>>> hdl/gsao_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gsao_checker
    import gsao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFS_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic [OUT_USER_W-1:0] last_mask_reg;

    // track the calibration flags of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mask_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_mask_reg <= m_axis_tuser;
        end
    end

    `ASSERT_NEXT(a_out_valid_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_out_data_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `ASSERT_IMPLY(a_mask_sticky, clk, rst_n, m_axis_tvalid && m_axis_tready, (m_axis_tuser & last_mask_reg) == last_mask_reg)
    `ASSERT_IMPLY_ALWAYS(a_reset_idle, clk, !rst_n, !m_axis_tvalid)

endmodule

bind gyro_still_auto_offset gsao_checker u_checker (.*);

>>> verif/gyro_rate_checker.sv
`timescale 1ns / 1ps

module gyro_rate_checker
    import gsao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFS_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // raw_rate_x [15:0], raw_rate_y [31:16], raw_rate_z [47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rate_out_x [25:0], rate_out_y [51:26], rate_out_z [77:52], zero [79:78]
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // calibrated_mask [2:0], zero [7:3]
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    failures,
    output int                    outstanding
);

    localparam longint RATE_HI = (longint'(1) <<< (RATE_W - 1)) - 1;
    localparam longint RATE_LO = -(longint'(1) <<< (RATE_W - 1));

    typedef struct packed {
        logic [NUM_AXES-1:0][RATE_W-1:0] rate;
        logic [NUM_AXES-1:0]             cal;
    } rate_result_t;

    logic signed [OFS_W-1:0]  manual_bias [NUM_AXES];
    logic [THR_W-1:0]         still_thr;
    logic signed [RATE_W-1:0] cur_rate    [NUM_AXES];
    logic signed [RATE_W-1:0] prev_rate   [NUM_AXES];
    logic [CNT_W-1:0]         still_cnt   [NUM_AXES];
    logic [ACNT_W-1:0]        avg_cnt     [NUM_AXES];
    logic signed [SUM_W-1:0]  avg_sum     [NUM_AXES];
    logic signed [RATE_W-1:0] learned_ofs [NUM_AXES];
    logic                     cal_done    [NUM_AXES];

    rate_result_t expected_rates [$];
    rate_result_t want;

    function automatic rate_result_t compensate_sample(input logic [IN_DATA_W-1:0] beat);
        rate_result_t            res;
        longint                  span;
        longint                  delta;
        longint                  level;
        logic signed [RAW_W-1:0] raw;
        span = longint'(still_thr) << FRAC_W;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            delta = longint'(cur_rate[a]) - longint'(prev_rate[a]);
            if (delta < 0)
                delta = -delta;
            if (delta < span)
                still_cnt[a] = still_cnt[a] + 1'b1;
            else
                for (int b = 0; b < NUM_AXES; b++)
                    still_cnt[b] = '0;
            prev_rate[a] = cur_rate[a];
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (still_cnt[a] > LEARN_LIMIT)
            begin
                if (!cal_done[a])
                begin
                    avg_cnt[a] = avg_cnt[a] + 1'b1;
                    avg_sum[a] = SUM_W'(longint'(avg_sum[a]) + longint'(cur_rate[a]));
                    if (avg_cnt[a] >= AVG_SAMPLES)
                    begin
                        learned_ofs[a] = RATE_W'(longint'(avg_sum[a]) / AVG_SAMPLES);
                        cal_done[a] = 1'b1;
                        avg_cnt[a] = '0;
                        avg_sum[a] = '0;
                    end
                end
                if (still_cnt[a] >= STILL_CAP)
                    still_cnt[a] = CNT_W'(AVG_SAMPLES);
            end
            else
            begin
                if (!cal_done[a])
                begin
                    learned_ofs[a] = '0;
                    avg_sum[a] = '0;
                end
                avg_cnt[a] = '0;
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            raw = beat[a*RAW_W +: RAW_W];
            level = (longint'(raw) <<< FRAC_W) - longint'(manual_bias[a])
                    - longint'(learned_ofs[a]);
            if (level > RATE_HI)
                level = RATE_HI;
            else if (level < RATE_LO)
                level = RATE_LO;
            cur_rate[a] = RATE_W'(level);
            res.rate[a] = cur_rate[a];
            res.cal[a] = cal_done[a];
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [OUT_DATA_W-1:0] exp_val,
                                 input logic [OUT_DATA_W-1:0] got_val);
        failures = failures + 1;
        if (failures <= 10)
            $display("%0t %s mismatch: expected %0h, got %0h", $realtime, what, exp_val,
                     got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                manual_bias[a] = '0;
                cur_rate[a] = '0;
                prev_rate[a] = '0;
                still_cnt[a] = '0;
                avg_cnt[a] = '0;
                avg_sum[a] = '0;
                learned_ofs[a] = '0;
                cal_done[a] = 1'b0;
            end
            still_thr = THR_RESET;
            expected_rates.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rates.size() == 0)
                    note_mismatch("unexpected result beat", '0, m_axis_tdata);
                else
                begin
                    want = expected_rates.pop_front();
                    for (int a = 0; a < NUM_AXES; a++)
                        if (m_axis_tdata[a*RATE_W +: RATE_W] !== want.rate[a])
                            note_mismatch($sformatf("rate_out axis %0d", a), want.rate[a],
                                          m_axis_tdata[a*RATE_W +: RATE_W]);
                    if (m_axis_tdata[OUT_DATA_W-1:NUM_AXES*RATE_W] !== '0)
                        note_mismatch("tdata padding", '0,
                                      m_axis_tdata[OUT_DATA_W-1:NUM_AXES*RATE_W]);
                    if (m_axis_tuser[NUM_AXES-1:0] !== want.cal)
                        note_mismatch("calibrated_mask", want.cal, m_axis_tuser[NUM_AXES-1:0]);
                    if (m_axis_tuser[OUT_USER_W-1:NUM_AXES] !== '0)
                        note_mismatch("tuser padding", '0, m_axis_tuser[OUT_USER_W-1:NUM_AXES]);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFS_X, REG_OFS_Y, REG_OFS_Z: manual_bias[cfg_index] = cfg_data;
                    REG_THR:                         still_thr = cfg_data[THR_W-1:0];
                    default:                         ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_rates.push_back(compensate_sample(s_axis_tdata));
        end
        outstanding = expected_rates.size();
    end

endmodule

>>> verif/gyro_still_auto_offset_tb.sv
`timescale 1ns / 1ps

module gyro_still_auto_offset_tb;

    import gsao_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RUN_LENGTH   = 1070;
    localparam int SPIKE_AT     = 506;
    localparam int HOLD_BEAT    = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int NOISE_ITEMS  = 15;
    localparam int TAIL_ITEMS   = 30;
    localparam int JITTER_SPAN  = 400;
    localparam int THR_TOP      = (1 << THR_W) - 1;

    localparam logic signed [RAW_W-1:0] RAW_TOP    = {1'b0, {(RAW_W-1){1'b1}}};
    localparam logic signed [RAW_W-1:0] RAW_BOTTOM = {1'b1, {(RAW_W-1){1'b0}}};
    localparam logic signed [OFS_W-1:0] OFS_TOP    = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_BOTTOM = {1'b1, {(OFS_W-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [OFS_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int failures;
    int outstanding;
    int cycles = 0;
    int beats_out = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    gyro_still_auto_offset uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gyro_rate_checker rate_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_rates(input logic signed [RAW_W-1:0] x, input logic signed [RAW_W-1:0] y,
                              input logic signed [RAW_W-1:0] z);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic settle(input int tail);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random back-pressure, one long hold to fill the block
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall = stall - 1;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_out = beats_out + 1;
                if (beats_out == HOLD_BEAT)
                    stall = HOLD_CYCLES;
                else
                begin
                    if ($urandom_range(0, 39) == 0)
                        recv_burst = !recv_burst;
                    stall = recv_burst ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    initial
    begin
        int                      thr_now;
        int                      stretch;
        int                      count;
        int                      step_k;
        logic signed [RAW_W-1:0] base  [NUM_AXES];
        logic signed [RAW_W-1:0] rates [NUM_AXES];

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_rates(0, 0, 0);
        send_rates(0, 0, 0);
        send_rates(RAW_TOP, RAW_BOTTOM, 0);
        send_rates(RAW_BOTTOM, RAW_TOP, -1);
        send_rates(100, 100, 100);
        send_rates(104, 96, 104);
        send_rates(109, 91, 100);
        send_rates(109, 91, 100);
        settle(4);
        write_reg(REG_OFS_X, OFS_BOTTOM);
        write_reg(REG_OFS_Y, OFS_TOP);
        write_reg(REG_OFS_Z, OFS_TOP);
        write_reg(REG_THR, OFS_W'(THR_TOP));
        send_rates(RAW_TOP, RAW_BOTTOM, RAW_TOP);
        send_rates(RAW_BOTTOM, RAW_TOP, RAW_BOTTOM);
        send_rates(RAW_TOP, RAW_TOP, RAW_BOTTOM);
        settle(4);
        write_reg(REG_THR, '0);
        send_rates(7, 7, 7);
        send_rates(7, 7, 7);
        send_rates(7, 7, 7);

        // noise: full-range jumps mixed with small steps, three threshold settings
        for (int a = 0; a < NUM_AXES; a++)
            rates[a] = '0;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            settle(4);
            write_reg(REG_OFS_X, OFS_W'($urandom()));
            write_reg(REG_OFS_Y, OFS_W'($urandom()));
            write_reg(REG_OFS_Z, OFS_W'($urandom()));
            if (chunk == 0)
                thr_now = $urandom_range(0, THR_TOP);
            else if (chunk == 1)
                thr_now = 0;
            else
                thr_now = $urandom_range(1, 16);
            write_reg(REG_THR, OFS_W'(thr_now));
            for (int n = 0; n < NOISE_ITEMS; n++)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        rates[a] = RAW_W'($urandom());
                    else
                    begin
                        step_k = $urandom_range(0, 8);
                        rates[a] = rates[a] + RAW_W'($urandom_range(0, 2 * step_k))
                                   - RAW_W'(step_k);
                    end
                end
                send_rates(rates[0], rates[1], rates[2]);
            end
        end

        // long still run at extreme bias: break once mid-average, then learn
        settle(4);
        write_reg(REG_OFS_X, OFS_BOTTOM);
        write_reg(REG_OFS_Y, OFS_TOP);
        write_reg(REG_OFS_Z, OFS_W'($urandom()));
        write_reg(REG_THR, OFS_W'(THR_TOP));
        base[2] = RAW_W'(int'($urandom_range(0, 60000)) - 30000);
        for (int n = 0; n < RUN_LENGTH; n++)
        begin
            if (n == SPIKE_AT)
                send_rates(0, RAW_BOTTOM, base[2]);
            else
                send_rates(RAW_TOP - RAW_W'($urandom_range(0, JITTER_SPAN)),
                           RAW_BOTTOM + RAW_W'($urandom_range(0, JITTER_SPAN)),
                           base[2] + RAW_W'($urandom_range(0, JITTER_SPAN)));
        end

        // flip the bias after learning: drive x toward the negative rail and y toward the positive rail
        settle(4);
        write_reg(REG_OFS_X, OFS_TOP);
        write_reg(REG_OFS_Y, OFS_BOTTOM);
        write_reg(REG_OFS_Z, OFS_W'($urandom()));
        thr_now = $urandom_range(8, 64);
        write_reg(REG_THR, OFS_W'(thr_now));
        base[0] = RAW_BOTTOM;
        base[1] = RAW_TOP;
        base[2] = RAW_W'($urandom());
        count = 0;
        while (count < TAIL_ITEMS)
        begin
            stretch = $urandom_range(5, 40);
            for (int k = 0; k < stretch; k++)
            begin
                send_rates(base[0] + RAW_W'($urandom_range(0, thr_now - 1)),
                           base[1] - RAW_W'($urandom_range(0, thr_now - 1)),
                           base[2] + RAW_W'($urandom_range(0, thr_now - 1)));
                count = count + 1;
            end
            send_rates(RAW_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()));
            base[2] = RAW_W'($urandom());
            count = count + 1;
        end

        settle(120);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/gsao_pkg.sv
hdl/gsao_front.sv
hdl/gsao_div.sv
hdl/gsao_back.sv
hdl/gyro_still_auto_offset.sv
hdl/gsao_checker.sv
verif/gyro_rate_checker.sv
verif/gyro_still_auto_offset_tb.sv
